[sv/spid_pkg.sv]
`timescale 1ns / 1ps

package spid_pkg;

    // Shared multiplier operand widths: a 27 x 25 signed product
    localparam int MUL_A_W  = 27;
    localparam int MUL_B_W  = 25;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    // Restoring divider: two quotient bits per cycle
    localparam int DIV_N_W  = 42;
    localparam int DIV_D_W  = 16;
    localparam int DIV_STEPS = DIV_N_W / 2;
    localparam int CNT_W    = 5;

    // PID accumulator and term limit (2^50)
    localparam int ACC_W    = 54;
    localparam int TERM_EXP = 50;
    localparam int ILO_W    = 26;
    localparam int IHI_W    = TERM_EXP + 1 - ILO_W;

    localparam int GAIN_W   = 24;
    localparam int ANGLE_W  = 16;
    localparam int ERR_W    = 17;
    localparam int DUTY_W   = 8;
    localparam int EFF_W    = 9;

    localparam logic [7:0] MODE_RADIO = 8'd1;
    localparam logic [7:0] MODE_AUTO  = 8'd2;

    localparam logic [2:0] CFG_GAIN_P    = 3'd0;
    localparam logic [2:0] CFG_GAIN_I    = 3'd1;
    localparam logic [2:0] CFG_GAIN_D    = 3'd2;
    localparam logic [2:0] CFG_POT_LEFT  = 3'd3;
    localparam logic [2:0] CFG_POT_RIGHT = 3'd4;
    localparam logic [2:0] CFG_ANG_LIM   = 3'd5;
    localparam logic [2:0] CFG_DEAD_BAND = 3'd6;
    localparam logic [2:0] CFG_PWR_LIM   = 3'd7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_ANG,
        OP_LDIV_ANG,
        OP_DIV,
        OP_ANGLE,
        OP_MUL_INC,
        OP_INTEG,
        OP_MUL_P,
        OP_MUL_D,
        OP_LDIV_D,
        OP_ADD_D,
        OP_MUL_ILO,
        OP_MUL_IHI,
        OP_ADD_I,
        OP_EFFORT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_ANG,
        S_LDIV_ANG,
        S_DIV_ANG,
        S_ANGLE,
        S_MUL_INC,
        S_INTEG,
        S_MUL_P,
        S_MUL_D,
        S_LDIV_D,
        S_DIV_D,
        S_ADD_D,
        S_MUL_ILO,
        S_MUL_IHI,
        S_ADD_I,
        S_EFFORT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

[sv/steering_pid_servo_controller.sv]
`timescale 1ns / 1ps

// Steering servo controller: PID position loop with a dead band.
// Input channel: one beat per control tick (i_valid / o_stall) carrying the
// mode byte, link freshness flags, both setpoint angles, the pot sample and
// the elapsed time. Output channel: one beat per tick (o_valid / i_stall)
// carrying the held drive direction and duty, the clamped effort and a flag
// telling whether the drive was rewritten.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data;
// write only while no tick is in flight.
// A tick runs through a sequencer that drives one shared 27x25 multiplier
// and a radix-4 restoring divider; the two divisions (pot-to-angle scaling
// and the derivative over elapsed time) dominate. One tick is in flight at
// a time; o_stall is low only when the sequencer is idle.
// The result sits in an output register, so the next beat is taken while
// it waits. If the receiver stalls, a finished tick waits in its last step
// until the output register frees; nothing is lost.
// Reset (synchronous, active low) clears the integral, previous error and
// held drive, and loads the configuration defaults.
module steering_pid_servo_controller
    import spid_pkg::*;
#(
    parameter int ADC_BITS        = 12,
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int INTEGRAL_BITS   = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_control_mode,
    input  logic                       i_radio_fresh,
    input  logic                       i_nav_fresh,
    input  logic signed [ANGLE_W-1:0]  i_nav_angle,
    input  logic signed [ANGLE_W-1:0]  i_radio_angle,
    input  logic [ADC_BITS-1:0]        i_pot_sample,
    input  logic [15:0]                i_elapsed_ms,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_steer_right,
    output logic [DUTY_W-1:0]          o_duty,
    output logic signed [EFF_W-1:0]    o_effort,
    output logic                       o_drive_updated,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [GAIN_W-1:0]          i_cfg_data
);

    // configuration registers
    logic [GAIN_W-1:0]   r_gain_p, r_gain_i, r_gain_d;
    logic [ADC_BITS-1:0] r_pot_left, r_pot_right;
    logic [13:0]         r_angle_limit;
    logic [11:0]         r_dead_band;
    logic [DUTY_W-1:0]   r_power_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= 24'd68608;
            r_gain_i      <= 24'd0;
            r_gain_d      <= 24'd98560;
            r_pot_left    <= ADC_BITS'(2945);
            r_pot_right   <= ADC_BITS'(770);
            r_angle_limit <= 14'd5980;
            r_dead_band   <= 12'd57;
            r_power_limit <= 8'd150;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P:    r_gain_p      <= i_cfg_data;
                CFG_GAIN_I:    r_gain_i      <= i_cfg_data;
                CFG_GAIN_D:    r_gain_d      <= i_cfg_data;
                CFG_POT_LEFT:  r_pot_left    <= i_cfg_data[ADC_BITS-1:0];
                CFG_POT_RIGHT: r_pot_right   <= i_cfg_data[ADC_BITS-1:0];
                CFG_ANG_LIM:   r_angle_limit <= i_cfg_data[13:0];
                CFG_DEAD_BAND: r_dead_band   <= i_cfg_data[11:0];
                CFG_PWR_LIM:   r_power_limit <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    t_cmd cmd;
    t_sts sts;

    spid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    spid_dpath #(
        .ADC_BITS        (ADC_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .INTEGRAL_BITS   (INTEGRAL_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_control_mode  (i_control_mode),
        .i_radio_fresh   (i_radio_fresh),
        .i_nav_fresh     (i_nav_fresh),
        .i_nav_angle     (i_nav_angle),
        .i_radio_angle   (i_radio_angle),
        .i_pot_sample    (i_pot_sample),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_gain_p        (r_gain_p),
        .i_gain_i        (r_gain_i),
        .i_gain_d        (r_gain_d),
        .i_pot_left      (r_pot_left),
        .i_pot_right     (r_pot_right),
        .i_angle_limit   (r_angle_limit),
        .i_dead_band     (r_dead_band),
        .i_power_limit   (r_power_limit),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_steer_right   (o_steer_right),
        .o_duty          (o_duty),
        .o_effort        (o_effort),
        .o_drive_updated (o_drive_updated)
    );

endmodule

[sv/spid_ctrl.sv]
`timescale 1ns / 1ps

module spid_ctrl
    import spid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_cmd.op   = OP_NONE;
        o_cmd.emit = 1'b0;
        o_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_MUL_ANG;
                end
            end
            S_MUL_ANG: begin
                o_cmd.op = OP_MUL_ANG;
                n_state  = S_LDIV_ANG;
            end
            S_LDIV_ANG: begin
                o_cmd.op = OP_LDIV_ANG;
                n_cnt    = '0;
                n_state  = S_DIV_ANG;
            end
            S_DIV_ANG: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.op = OP_ANGLE;
                n_state  = S_MUL_INC;
            end
            S_MUL_INC: begin
                o_cmd.op = OP_MUL_INC;
                n_state  = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = S_MUL_P;
            end
            S_MUL_P: begin
                o_cmd.op = OP_MUL_P;
                n_state  = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.op = OP_MUL_D;
                n_state  = S_LDIV_D;
            end
            S_LDIV_D: begin
                o_cmd.op = OP_LDIV_D;
                n_cnt    = '0;
                n_state  = S_DIV_D;
            end
            S_DIV_D: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_ADD_D;
            end
            S_ADD_D: begin
                o_cmd.op = OP_ADD_D;
                n_state  = S_MUL_ILO;
            end
            S_MUL_ILO: begin
                o_cmd.op = OP_MUL_ILO;
                n_state  = S_MUL_IHI;
            end
            S_MUL_IHI: begin
                o_cmd.op = OP_MUL_IHI;
                n_state  = S_ADD_I;
            end
            S_ADD_I: begin
                o_cmd.op = OP_ADD_I;
                n_state  = S_EFFORT;
            end
            S_EFFORT: begin
                // wait here until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.op   = OP_EFFORT;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[sv/spid_dpath.sv]
`timescale 1ns / 1ps

module spid_dpath
    import spid_pkg::*;
#(
    parameter int ADC_BITS        = 12,
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int INTEGRAL_BITS   = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    // item
    input  logic [7:0]                 i_control_mode,
    input  logic                       i_radio_fresh,
    input  logic                       i_nav_fresh,
    input  logic signed [ANGLE_W-1:0]  i_nav_angle,
    input  logic signed [ANGLE_W-1:0]  i_radio_angle,
    input  logic [ADC_BITS-1:0]        i_pot_sample,
    input  logic [15:0]                i_elapsed_ms,
    // config
    input  logic [GAIN_W-1:0]          i_gain_p,
    input  logic [GAIN_W-1:0]          i_gain_i,
    input  logic [GAIN_W-1:0]          i_gain_d,
    input  logic [ADC_BITS-1:0]        i_pot_left,
    input  logic [ADC_BITS-1:0]        i_pot_right,
    input  logic [13:0]                i_angle_limit,
    input  logic [11:0]                i_dead_band,
    input  logic [DUTY_W-1:0]          i_power_limit,
    // result
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic                       o_steer_right,
    output logic [DUTY_W-1:0]          o_duty,
    output logic signed [EFF_W-1:0]    o_effort,
    output logic                       o_drive_updated
);

    localparam int IB = INTEGRAL_BITS;
    localparam int SW = ((IB > 34) ? IB : 34) + 1;
    localparam int SH = ANGLE_FRAC_BITS + 8;

    // captured item
    logic signed [ANGLE_W-1:0]  r_setp;
    logic [ADC_BITS-1:0]        r_pot;
    logic [15:0]                r_elapsed;

    // working registers
    logic signed [MUL_P_W-1:0]  r_prod;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [ERR_W:0]      r_diff;
    logic signed [ACC_W-1:0]    r_acc;
    logic [IB-1:0]              r_imag;
    logic [MUL_A_W+GAIN_W-2:0]  r_ilo;
    logic [TERM_EXP:0]          r_ip;
    logic [DIV_D_W-1:0]         r_rem;
    logic [DIV_N_W-1:0]         r_quo;
    logic [DIV_D_W-1:0]         r_dvs;
    logic                       r_qneg;

    // persistent state
    logic signed [IB-1:0]       r_integ;
    logic signed [ERR_W-1:0]    r_prev;
    logic [DUTY_W-1:0]          r_held_duty;
    logic                       r_held_dir;
    logic                       r_ovalid;

    // multiplier
    logic signed [MUL_A_W-1:0]  ma;
    logic signed [MUL_B_W-1:0]  mb;
    logic signed [MUL_P_W-1:0]  mprod;
    logic [63:0]                m64;

    assign m64 = 64'(r_imag);

    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            OP_MUL_ANG: begin
                ma = MUL_A_W'($signed({1'b0, r_pot}) - $signed({1'b0, i_pot_left}));
                mb = MUL_B_W'({i_angle_limit, 1'b0});
            end
            OP_MUL_INC: begin
                ma = MUL_A_W'(r_err);
                mb = MUL_B_W'(r_elapsed);
            end
            OP_MUL_P: begin
                ma = MUL_A_W'(r_err);
                mb = MUL_B_W'(i_gain_p);
            end
            OP_MUL_D: begin
                ma = MUL_A_W'(r_diff);
                mb = MUL_B_W'(i_gain_d);
            end
            OP_MUL_ILO: begin
                ma = MUL_A_W'(m64[ILO_W-1:0]);
                mb = MUL_B_W'(i_gain_i);
            end
            OP_MUL_IHI: begin
                ma = MUL_A_W'(m64[TERM_EXP:ILO_W]);
                mb = MUL_B_W'(i_gain_i);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mprod = ma * mb;

    // product magnitude feeding the divider
    logic [MUL_P_W-1:0] pabs;
    assign pabs = r_prod[MUL_P_W-1] ? MUL_P_W'(-r_prod) : MUL_P_W'(r_prod);

    logic signed [ADC_BITS:0] den;
    logic [ADC_BITS:0]        den_abs;
    assign den     = $signed({1'b0, i_pot_right}) - $signed({1'b0, i_pot_left});
    assign den_abs = den[ADC_BITS] ? (ADC_BITS+1)'(-den) : (ADC_BITS+1)'(den);

    // two restoring steps per cycle
    logic [DIV_D_W-1:0] dv_rem;
    logic [DIV_N_W-1:0] dv_quo;
    logic [DIV_D_W:0]   dv_t;
    always_comb begin
        dv_rem = r_rem;
        dv_quo = r_quo;
        dv_t   = '0;
        for (int k = 0; k < 2; k++) begin
            dv_t = {dv_rem, dv_quo[DIV_N_W-1]};
            if (dv_t >= {1'b0, r_dvs}) begin
                dv_t   = dv_t - {1'b0, r_dvs};
                dv_quo = {dv_quo[DIV_N_W-2:0], 1'b1};
            end else begin
                dv_quo = {dv_quo[DIV_N_W-2:0], 1'b0};
            end
            dv_rem = dv_t[DIV_D_W-1:0];
        end
    end

    logic signed [DIV_N_W:0] qs;
    assign qs = r_qneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    // angle and error
    logic signed [DIV_N_W+1:0] a_full;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [ERR_W-1:0]   err;
    always_comb begin
        a_full = (DIV_N_W+2)'(qs) - (DIV_N_W+2)'($signed({1'b0, i_angle_limit}));
        if (den == '0)                 angle = '0;
        else if (a_full > 44'sd32767)  angle = 16'sh7FFF;
        else if (a_full < -44'sd32768) angle = 16'sh8000;
        else                           angle = a_full[ANGLE_W-1:0];
        err = ERR_W'(r_setp) - ERR_W'(angle);
    end

    // saturating integral update
    logic signed [SW-1:0] isum;
    logic [SW-IB:0]       itop;
    logic                 iovf;
    logic signed [IB-1:0] inext;
    always_comb begin
        isum  = SW'(r_integ) + SW'($signed(r_prod[2*ERR_W-1:0]));
        itop  = isum[SW-1:IB-1];
        iovf  = !((&itop) || !(|itop));
        if (!iovf)             inext = isum[IB-1:0];
        else if (isum[SW-1])   inext = {1'b1, {(IB-1){1'b0}}};
        else                   inext = {1'b0, {(IB-1){1'b1}}};
    end

    // integral term magnitude, saturated at 2^50
    logic                big;
    logic [TERM_EXP+1:0] isat;
    always_comb begin
        big  = (i_gain_i != '0) && ((|m64[63:TERM_EXP+1]) || (|mprod[MUL_P_W-1:IHI_W]));
        isat = {1'b0, mprod[IHI_W-1:0], {ILO_W{1'b0}}} + (TERM_EXP+2)'(r_ilo);
    end

    // effort
    logic [ACC_W-1:0]  amag;
    logic [ACC_W-1:0]  aq;
    logic [DUTY_W-1:0] cl;
    always_comb begin
        amag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        aq   = amag >> SH;
        cl   = (aq > ACC_W'(i_power_limit)) ? i_power_limit : aq[DUTY_W-1:0];
    end

    logic signed [ERR_W-1:0] db;
    assign db = $signed({{(ERR_W-12){1'b0}}, i_dead_band});

    logic signed [EFF_W-1:0] eff;
    logic                    err_gt, err_lt;
    assign eff    = r_acc[ACC_W-1] ? -$signed({1'b0, cl}) : $signed({1'b0, cl});
    assign err_gt = r_err > db;
    assign err_lt = r_err < -db;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op) inside
            OP_LOAD: begin
                if (i_control_mode == MODE_AUTO && i_radio_fresh && i_nav_fresh)
                    r_setp <= i_nav_angle;
                else if (i_control_mode == MODE_RADIO && i_radio_fresh)
                    r_setp <= i_radio_angle;
                else
                    r_setp <= '0;
                r_pot     <= i_pot_sample;
                r_elapsed <= i_elapsed_ms;
            end
            OP_MUL_ANG, OP_MUL_INC, OP_MUL_D: r_prod <= mprod;
            OP_LDIV_ANG: begin
                r_rem  <= '0;
                r_quo  <= pabs[DIV_N_W-1:0];
                r_dvs  <= DIV_D_W'(den_abs);
                r_qneg <= r_prod[MUL_P_W-1] ^ den[ADC_BITS];
            end
            OP_LDIV_D: begin
                r_rem  <= '0;
                r_quo  <= pabs[DIV_N_W-1:0];
                r_dvs  <= r_elapsed;
                r_qneg <= r_prod[MUL_P_W-1];
            end
            OP_DIV: begin
                r_rem <= dv_rem;
                r_quo <= dv_quo;
            end
            OP_ANGLE: begin
                r_err  <= err;
                r_diff <= (ERR_W+1)'(err) - (ERR_W+1)'(r_prev);
            end
            OP_MUL_P: r_acc <= ACC_W'(mprod);
            OP_ADD_D: begin
                if (r_elapsed != '0) r_acc <= r_acc + ACC_W'(qs);
                r_imag <= r_integ[IB-1] ? IB'(-r_integ) : IB'(r_integ);
            end
            OP_MUL_ILO: r_ilo <= mprod[MUL_A_W+GAIN_W-2:0];
            OP_MUL_IHI: begin
                if (big || isat > (TERM_EXP+2)'(1) << TERM_EXP)
                    r_ip <= (TERM_EXP+1)'(1) << TERM_EXP;
                else
                    r_ip <= isat[TERM_EXP:0];
            end
            OP_ADD_I: begin
                if (r_integ[IB-1]) r_acc <= r_acc - ACC_W'(r_ip);
                else               r_acc <= r_acc + ACC_W'(r_ip);
            end
            default: ;
        endcase
        if (i_cmd.op == OP_EFFORT) begin
            // result payload
            if (err_gt) begin
                o_effort        <= eff;
                o_drive_updated <= 1'b1;
                o_steer_right   <= 1'b1;
                o_duty          <= eff[EFF_W-1] ? '0 : eff[DUTY_W-1:0];
            end else if (err_lt) begin
                o_effort        <= eff;
                o_drive_updated <= 1'b1;
                o_steer_right   <= 1'b0;
                o_duty          <= cl;
            end else begin
                o_effort        <= '0;
                o_drive_updated <= 1'b0;
                o_steer_right   <= r_held_dir;
                o_duty          <= r_held_duty;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_prev      <= '0;
            r_held_duty <= '0;
            r_held_dir  <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cmd.op == OP_INTEG) r_integ <= inext;
            if (i_cmd.emit) begin
                r_prev   <= r_err;
                r_ovalid <= 1'b1;
                if (err_gt) begin
                    r_held_dir  <= 1'b1;
                    r_held_duty <= eff[EFF_W-1] ? '0 : eff[DUTY_W-1:0];
                end else if (err_lt) begin
                    r_held_dir  <= 1'b0;
                    r_held_duty <= cl;
                end
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sts.out_busy = r_ovalid && i_stall;

endmodule

[tb/sv/tb_steering_pid_servo_controller.sv]
`timescale 1ns / 1ps

module tb_steering_pid_servo_controller;
    import spid_pkg::*;

    localparam int LATENCY    = 57;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [7:0]         mode;
        logic               radio;
        logic               nav;
        logic signed [15:0] nav_ang;
        logic signed [15:0] radio_ang;
        logic [11:0]        pot;
        logic [15:0]        dt;
    } t_tick;

    typedef struct packed {
        logic              right;
        logic [7:0]        duty;
        logic signed [8:0] effort;
        logic              updated;
    } t_drive;

    // directed row: tick plus an optional typed-in expectation
    typedef struct packed {
        t_tick  tick;
        logic   typed;
        t_drive drive;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [7:0] i_control_mode = '0;
    logic i_radio_fresh = 1'b0;
    logic i_nav_fresh = 1'b0;
    logic signed [15:0] i_nav_angle = '0;
    logic signed [15:0] i_radio_angle = '0;
    logic [11:0] i_pot_sample = '0;
    logic [15:0] i_elapsed_ms = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_steer_right;
    logic [7:0] o_duty;
    logic signed [8:0] o_effort;
    logic o_drive_updated;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    always #2 i_clk = ~i_clk;

    steering_pid_servo_controller u_top (.*);

    // predictor copy of registers and loop state
    longint kp, ki, kd, pot_l, pot_r, ang_lim, dband, pwr_lim;
    longint integ, prev_err, held_duty, held_dir;
    t_drive drive_q[$];
    int     errors = 0;
    int     wdog = 0;
    bit     stall_pat_on = 1'b1;

    function automatic longint sat_term(longint v);
        longint lim;
        lim = longint'(1) << 50;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_drive pid_tick(t_tick t);
        longint sp, ang, den, err, inc, imax, dterm, iterm, m, sum, q, eff;
        t_drive r;
        imax = (longint'(1) << 47) - 1;
        if (t.mode == MODE_AUTO && t.radio && t.nav) sp = t.nav_ang;
        else if (t.mode == MODE_RADIO && t.radio) sp = t.radio_ang;
        else sp = 0;
        den = pot_r - pot_l;
        if (den == 0) ang = 0;
        else begin
            ang = (longint'(t.pot) - pot_l) * (2 * ang_lim) / den - ang_lim;
            if (ang > 32767) ang = 32767;
            if (ang < -32768) ang = -32768;
        end
        err = sp - ang;
        inc = err * longint'(t.dt);
        integ = integ + inc;
        if (integ > imax) integ = imax;
        if (integ < -imax - 1) integ = -imax - 1;
        dterm = (t.dt == 0) ? 0 : (kd * (err - prev_err)) / longint'(t.dt);
        m = integ < 0 ? -integ : integ;
        if (ki == 0 || m == 0) iterm = 0;
        else if (m > (longint'(1) << 50) / ki) iterm = longint'(1) << 50;
        else iterm = m * ki;
        if (integ < 0) iterm = -iterm;
        sum = sat_term(kp * err) + iterm + sat_term(dterm);
        q = (sum < 0 ? -sum : sum) >>> 21;
        eff = sum < 0 ? -q : q;
        if (eff < -pwr_lim) eff = -pwr_lim;
        if (eff > pwr_lim) eff = pwr_lim;
        prev_err = err;
        r.updated = 1'b1;
        if (err > dband) begin
            held_dir = 1;
            held_duty = eff < 0 ? 0 : eff;
        end else if (err < -dband) begin
            held_dir = 0;
            held_duty = eff < 0 ? -eff : eff;
        end else begin
            eff = 0;
            r.updated = 1'b0;
        end
        r.right = held_dir[0];
        r.duty = held_duty[7:0];
        r.effort = eff[8:0];
        return r;
    endfunction

    // receiver: stall pattern, checks each beat against oldest expectation
    always @(posedge i_clk) begin
        t_drive e;
        if (o_valid && !i_stall && i_rst_n) begin
            if (drive_q.size() == 0) begin
                $error("unexpected beat");
                errors++;
            end else begin
                e = drive_q.pop_front();
                if (o_steer_right !== e.right) begin
                    $error("steer_right exp %0d got %0d", e.right, o_steer_right);
                    errors++;
                end
                if (o_duty !== e.duty) begin
                    $error("duty exp %0d got %0d", e.duty, o_duty);
                    errors++;
                end
                if (o_effort !== e.effort) begin
                    $error("effort exp %0d got %0d", e.effort, o_effort);
                    errors++;
                end
                if (o_drive_updated !== e.updated) begin
                    $error("drive_updated exp %0d got %0d", e.updated, o_drive_updated);
                    errors++;
                end
            end
        end
        // stall in phases: sometimes none, sometimes heavy
        if ($urandom_range(0, 199) == 0) stall_pat_on <= ~stall_pat_on;
        i_stall <= stall_pat_on ? ($urandom_range(0, 3) == 0) : 1'b0;
    end

    // watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one write, then i_cfg_we is dropped before returning so back-to-back writes never collide
    task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN_P:    kp = val;
            CFG_GAIN_I:    ki = val;
            CFG_GAIN_D:    kd = val;
            CFG_POT_LEFT:  pot_l = val[11:0];
            CFG_POT_RIGHT: pot_r = val[11:0];
            CFG_ANG_LIM:   ang_lim = val[13:0];
            CFG_DEAD_BAND: dband = val[11:0];
            default:       pwr_lim = val[7:0];
        endcase
    endtask

    // sends one beat, holds valid until taken; gaps only between beats
    task automatic send_tick(t_tick t, bit keep);
        i_valid <= 1'b1;
        i_control_mode <= t.mode;
        i_radio_fresh <= t.radio;
        i_nav_fresh <= t.nav;
        i_nav_angle <= t.nav_ang;
        i_radio_angle <= t.radio_ang;
        i_pot_sample <= t.pot;
        i_elapsed_ms <= t.dt;
        do @(posedge i_clk); while (o_stall);
        drive_q.push_back(pid_tick(t));
        if (!keep) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic t_tick rand_tick();
        t_tick t;
        int sel;
        sel = $urandom_range(0, 9);
        t.mode = sel < 4 ? MODE_AUTO : sel < 8 ? MODE_RADIO : 8'($urandom);
        t.radio = ($urandom_range(0, 5) != 0);
        t.nav = ($urandom_range(0, 5) != 0);
        t.nav_ang = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($signed($urandom_range(0, 12000)) - 6000);
        t.radio_ang = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($signed($urandom_range(0, 12000)) - 6000);
        t.pot = 12'($urandom);
        sel = $urandom_range(0, 9);
        t.dt = sel == 0 ? 16'd0 : sel == 1 ? 16'($urandom) : 16'($urandom_range(1, 100));
        return t;
    endfunction

    // random burst of ticks; gaps between bursts
    task automatic run_random(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && n > 0; k++) begin
                n--;
                send_tick(rand_tick(), (k < burst - 1) && (n > 0));
            end
            repeat ($urandom_range(0, 80)) @(posedge i_clk);
        end
    endtask

    t_row rows[12];

    initial begin
        t_row r;
        kp = 68608; ki = 0; kd = 98560; pot_l = 2945; pot_r = 770;
        ang_lim = 5980; dband = 57; pwr_lim = 150;
        integ = 0; prev_err = 0; held_duty = 0; held_dir = 0;

        // mode, radio, nav, nav_ang, radio_ang, pot, dt | typed, right, duty, eff, upd
        // pot at midpoint (1857) maps near zero; center mode gives small error
        rows[0]  = '{'{8'd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 12'd1857, 16'd50},
                     1'b0, '0};
        rows[1]  = '{'{MODE_AUTO, 1'b1, 1'b1, 16'sh7fff, 16'sd0, 12'd1857, 16'd50},
                     1'b1, '{1'b1, 8'd150, 9'sd150, 1'b1}};
        rows[2]  = '{'{MODE_AUTO, 1'b1, 1'b1, -16'sd32768, 16'sd0, 12'd1857, 16'd0},
                     1'b1, '{1'b0, 8'd150, -9'sd150, 1'b1}};
        rows[3]  = '{'{MODE_RADIO, 1'b1, 1'b0, 16'sd0, 16'sh7fff, 12'd0, 16'hffff},
                     1'b0, '0};
        rows[4]  = '{'{MODE_RADIO, 1'b1, 1'b1, 16'sd0, -16'sd32768, 12'hfff, 16'd1},
                     1'b0, '0};
        rows[5]  = '{'{MODE_RADIO, 1'b0, 1'b1, 16'sd5000, 16'sd5000, 12'd770, 16'd20},
                     1'b0, '0};
        rows[6]  = '{'{MODE_AUTO, 1'b0, 1'b1, 16'sd5000, 16'sd0, 12'd2945, 16'd20},
                     1'b0, '0};
        rows[7]  = '{'{8'hff, 1'b1, 1'b1, 16'sd5000, 16'sd5000, 12'd1857, 16'd20},
                     1'b0, '0};
        rows[8]  = '{'{MODE_AUTO, 1'b1, 1'b1, 16'sd3000, 16'sd0, 12'd2000, 16'd0},
                     1'b0, '0};
        // right with negative effort: big previous error falling sharply
        rows[9]  = '{'{MODE_AUTO, 1'b1, 1'b1, 16'sd200, 16'sd0, 12'd1857, 16'd1},
                     1'b0, '0};
        rows[10] = '{'{MODE_AUTO, 1'b1, 1'b1, -16'sd200, 16'sd0, 12'd1857, 16'd1},
                     1'b0, '0};
        rows[11] = '{'{MODE_AUTO, 1'b1, 1'b1, 16'sd0, 16'sd0, 12'd1857, 16'd7},
                     1'b0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: directed table
        foreach (rows[n]) begin
            r = rows[n];
            send_tick(r.tick, 1'b0);
            if (r.typed && drive_q[$] !== r.drive) begin
                $error("directed row %0d: table exp %h pred %h", n, r.drive, drive_q[$]);
                errors++;
            end
        end
        // sender holds off until everything has come back
        drain();

        // equal pot limits, zero power limit, integral gain at max
        cfg_write(CFG_POT_LEFT, 24'd1000);
        cfg_write(CFG_POT_RIGHT, 24'd1000);
        cfg_write(CFG_PWR_LIM, 24'd0);
        cfg_write(CFG_GAIN_I, 24'hffffff);
        send_tick(rows[1].tick, 1'b0);
        send_tick(rows[2].tick, 1'b0);
        run_random(50);
        drain();

        // gains, angle limit, dead band and power limit at max; pot limits at full span
        cfg_write(CFG_GAIN_P, 24'hffffff);
        cfg_write(CFG_GAIN_D, 24'hffffff);
        cfg_write(CFG_POT_LEFT, 24'hfff);
        cfg_write(CFG_POT_RIGHT, 24'd0);
        cfg_write(CFG_ANG_LIM, 24'h3fff);
        cfg_write(CFG_DEAD_BAND, 24'hfff);
        cfg_write(CFG_PWR_LIM, 24'hff);
        run_random(150);
        drain();

        // gains, angle limit and dead band at zero; pot limits at full span
        cfg_write(CFG_GAIN_P, 24'd0);
        cfg_write(CFG_GAIN_I, 24'd0);
        cfg_write(CFG_GAIN_D, 24'd0);
        cfg_write(CFG_POT_LEFT, 24'd0);
        cfg_write(CFG_POT_RIGHT, 24'hfff);
        cfg_write(CFG_ANG_LIM, 24'd0);
        cfg_write(CFG_DEAD_BAND, 24'd0);
        run_random(100);
        drain();

        // random moderate settings, several phases
        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(CFG_GAIN_P, 24'($urandom_range(0, 200000)));
            cfg_write(CFG_GAIN_I, 24'($urandom_range(0, 300)));
            cfg_write(CFG_GAIN_D, 24'($urandom_range(0, 200000)));
            cfg_write(CFG_POT_LEFT, 24'($urandom_range(2000, 4095)));
            cfg_write(CFG_POT_RIGHT, 24'($urandom_range(0, 2000)));
            cfg_write(CFG_ANG_LIM, 24'($urandom_range(0, 16383)));
            cfg_write(CFG_DEAD_BAND, 24'($urandom_range(0, 200)));
            cfg_write(CFG_PWR_LIM, 24'($urandom_range(0, 255)));
            run_random(140);
            drain();
        end

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
